/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sort-and-median checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SMD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/smd_pkg.sv */
// ----------------------------------------------------------------------------
// smd_pkg
// Types and fixed widths shared by the sort-and-median block.
// ----------------------------------------------------------------------------
package smd_pkg;

   localparam int IN_W        = 16;
   localparam int SORTED_W    = 16;
   localparam int POS_W       = 6;
   localparam int COUNT_W     = 7;
   localparam int MED_W       = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_MEDIAN = 3'b010,
      ST_EMIT   = 3'b100
   } back_state_type;

   typedef struct packed {
      logic avail;
      logic last;
   } queue_status_type;

endpackage

/* rtl/smd_front.sv */
// ----------------------------------------------------------------------------
// smd_front
// Input side: takes request beats, trims values to the stored width and
// queues them for the sorter.
// ----------------------------------------------------------------------------
module smd_front import smd_pkg::*; #(
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [IN_W-1:0]       req_value,
   input  logic                  req_final_value,
   input  logic                  pop,
   output logic [VALUE_BITS-1:0] q_value,
   output queue_status_type      q_status
);

   localparam int KEEP_W = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;

   logic [VALUE_BITS-1:0] val_mem_ff [QUEUE_DEPTH];
   logic                  last_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       fill_ff, fill_in;
   logic                  push;
   logic [VALUE_BITS-1:0] value_kept;

   assign value_kept = VALUE_BITS'(req_value[KEEP_W-1:0]);
   assign req_ready  = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;

   assign q_value        = val_mem_ff[rd_ptr_ff];
   assign q_status.avail = (fill_ff != '0);
   assign q_status.last  = last_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         val_mem_ff[wr_ptr_ff]  <= value_kept;
         last_mem_ff[wr_ptr_ff] <= req_final_value;
      end
   end

endmodule

/* rtl/smd_back.sv */
// ----------------------------------------------------------------------------
// smd_back
// Sorter: insertion into a row of ordered cells, a rotation pass that picks
// out the median, then a rotation pass that streams the set out.
// ----------------------------------------------------------------------------
module smd_back import smd_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VALUE_BITS-1:0] q_value,
   input  queue_status_type      q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SORTED_W-1:0]   rsp_sorted_value,
   output logic [POS_W-1:0]      rsp_position,
   output logic [COUNT_W-1:0]    rsp_set_count,
   output logic [MED_W-1:0]      rsp_median_doubled,
   output logic                  rsp_overflowed,
   output logic                  rsp_last_of_run
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   back_state_type        state_ff, state_in;
   logic [VALUE_BITS-1:0] cell_ff [CAPACITY];
   logic [VALUE_BITS-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0]   gt;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   logic [VALUE_BITS:0]   med_ff, med_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SORTED_W-1:0]   out_value_ff;
   logic [POS_W-1:0]      out_pos_ff;
   logic [COUNT_W-1:0]    out_count_ff;
   logic [MED_W-1:0]      out_med_ff;
   logic                  out_ovf_ff;
   logic                  out_last_ff;

   logic                  full;
   logic                  step_last;
   logic [CNT_W-1:0]      half;
   logic [CNT_W-1:0]      step_ext;
   logic                  out_free;
   logic                  do_insert;
   logic                  rotate;
   logic                  emit_beat;
   logic [VALUE_BITS:0]   head_ext;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign step_ext  = CNT_W'(step_ff);
   assign step_last = ((step_ext + CNT_W'(1)) == count_ff);
   assign half      = count_ff >> 1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_LOAD) && q_status.avail;
   assign do_insert = pop && !full;
   assign emit_beat = (state_ff == ST_EMIT) && out_free;
   assign rotate    = (state_ff == ST_MEDIAN) || emit_beat;
   assign head_ext  = {1'b0, cell_ff[0]};

   // a cell takes part in the shift if it is empty or holds a larger value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i] = (CNT_W'(i) >= count_ff) || (cell_ff[i] > q_value);
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (do_insert) begin
         if (gt[0]) begin
            cell_in[0] = q_value;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (gt[i]) begin
               cell_in[i] = gt[i-1] ? cell_ff[i-1] : q_value;
            end
         end
      end else if (rotate) begin
         // rotate left, wrapping at the held count
         for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_in[i] = (CNT_W'(i + 1) == count_ff) ? cell_ff[0] : cell_ff[i+1];
         end
         cell_in[CAPACITY-1] = cell_ff[0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      med_in       = med_ff;
      case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (q_status.last) begin
                  state_in = ST_MEDIAN;
                  step_in  = '0;
                  med_in   = '0;
               end
            end
         end
         ST_MEDIAN: begin
            step_in = step_ff + 1'b1;
            if (!count_ff[0] && ((step_ext + CNT_W'(1)) == half)) begin
               med_in = head_ext;
            end
            if (step_ext == half) begin
               med_in = (count_ff[0] ? head_ext : med_ff) + head_ext;
            end
            if (step_last) begin
               state_in = ST_EMIT;
               step_in  = '0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               step_in = step_ff + 1'b1;
               if (step_last) begin
                  state_in = ST_LOAD;
                  step_in  = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      if (emit_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      med_ff <= med_in;
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      if (emit_beat) begin
         out_value_ff <= SORTED_W'(cell_ff[0]);
         out_pos_ff   <= POS_W'(step_ff);
         out_count_ff <= COUNT_W'(count_ff);
         out_med_ff   <= MED_W'(med_ff);
         out_ovf_ff   <= ovf_ff;
         out_last_ff  <= step_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sorted_value   = out_value_ff;
   assign rsp_position       = out_pos_ff;
   assign rsp_set_count      = out_count_ff;
   assign rsp_median_doubled = out_med_ff;
   assign rsp_overflowed     = out_ovf_ff;
   assign rsp_last_of_run    = out_last_ff;

endmodule

/* rtl/sort_and_median_top.sv */
// ----------------------------------------------------------------------------
// sort_and_median_top
// Collects values, sorts each set and streams it out with count and median.
//
// Usage:
//   req_ channel: one value per beat; req_final_value closes the set. Values
//   past CAPACITY are dropped and flagged on every result of that set.
//   rsp_ channel: one beat per held value, ascending, each carrying rank, set
//   count, doubled median and overflow; rsp_last_of_run marks the last one.
//   Loading: a 4-entry queue feeds an insertion row of CAPACITY cells, one
//   value per cycle while the sorter is in its load state; req_ready drops
//   only when the queue is full. After the final value is inserted, a
//   rotation pass finds the median, then the set leaves at one beat per
//   cycle while rsp_ready allows it. A stalled rsp_ready holds the output
//   register and pauses the sorter; new values keep filling the queue
//   meanwhile.
//   Reset (synchronous, active high) empties the queue and the set and drops
//   any result in flight.
// ----------------------------------------------------------------------------
module sort_and_median_top import smd_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [IN_W-1:0]     req_value,
   input  logic                req_final_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SORTED_W-1:0] rsp_sorted_value,
   output logic [POS_W-1:0]    rsp_position,
   output logic [COUNT_W-1:0]  rsp_set_count,
   output logic [MED_W-1:0]    rsp_median_doubled,
   output logic                rsp_overflowed,
   output logic                rsp_last_of_run
);

   logic [VALUE_BITS-1:0] q_value;
   queue_status_type      q_status;
   logic                  pop;

   smd_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_final_value (req_final_value),
      .pop             (pop),
      .q_value         (q_value),
      .q_status        (q_status)
   );

   smd_back #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_value            (q_value),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sorted_value   (rsp_sorted_value),
      .rsp_position       (rsp_position),
      .rsp_set_count      (rsp_set_count),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_overflowed     (rsp_overflowed),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

/* rtl/smd_checker.sv */
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks on the result stream of the sort-and-median block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smd_checker import smd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SORTED_W-1:0] rsp_sorted_value,
   input logic [POS_W-1:0]    rsp_position,
   input logic [COUNT_W-1:0]  rsp_set_count,
   input logic [MED_W-1:0]    rsp_median_doubled,
   input logic                rsp_overflowed,
   input logic                rsp_last_of_run
);

   `SMD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_position) && $stable(rsp_overflowed), "result beat changed while stalled")

   `SMD_ASSERT_IMP(a_last_rank, clock, reset, rsp_valid && rsp_last_of_run, (COUNT_W'(rsp_position) + COUNT_W'(1)) == rsp_set_count, "last beat rank does not match set count")

   `SMD_ASSERT_IMP(a_mid_rank, clock, reset, rsp_valid && !rsp_last_of_run, (COUNT_W'(rsp_position) + COUNT_W'(1)) < rsp_set_count, "rank past end of set without last flag")

   `SMD_ASSERT_IMP(a_median_bound, clock, reset, rsp_valid && rsp_last_of_run, rsp_median_doubled <= {rsp_sorted_value, 1'b0}, "median exceeds largest value")

endmodule

bind sort_and_median_top smd_checker u_smd_checker (.*);
